FILE: rtl/emac_pkg.sv
// Shared types, constants and command/status structs for the moving average crossover block.
package emac_pkg;

  localparam int unsigned MaxWindowDef = 1024;
  localparam int unsigned PriceW       = 42;
  localparam int unsigned SumW         = 52;
  localparam int unsigned RegW         = 10;
  localparam int unsigned CfgIdxW      = 1;
  localparam logic [CfgIdxW-1:0] CfgFast = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSlow = 1'b1;

  localparam logic [1:0] StValid   = 2'd0;
  localparam logic [1:0] StWarming = 2'd1;
  localparam logic [1:0] StRange   = 2'd2;
  localparam logic [1:0] StWindows = 2'd3;

  localparam logic signed [1:0] DirUp   = 2'sd1;
  localparam logic signed [1:0] DirDown = -2'sd1;
  localparam logic signed [1:0] DirFlat = 2'sd0;

  typedef enum logic [3:0] {
    S_IDLE, S_RDF, S_RDS, S_UPD, S_FST, S_DIVF, S_DIVS, S_MUL, S_CMP, S_OUT
  } emac_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture input word, check it
    logic rd_fast;   // read ring entry fast_window back
    logic rd_slow;   // read ring entry slow_window back, latch fast read
    logic update;    // update sums, ring, pointers
    logic div_start; // start a division
    logic div_sel;   // 0 fast sum, 1 slow sum
    logic mul;       // remainder cross-products
    logic compare;   // form direction
  } emac_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic reject;    // item is rejected (status already known)
    logic full;      // window full after update
    logic div_done;
  } emac_sts_t;

endpackage

FILE: rtl/emac_ctrl.sv
// Sequencing state machine of the moving average crossover block.
module emac_ctrl
  import emac_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output emac_cmd_t cmd_o,
  input  emac_sts_t sts_i
);

  emac_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_RDF;
      S_RDF:  state_d = sts_i.reject ? S_OUT : S_RDS;
      S_RDS:  state_d = S_UPD;
      S_UPD:  state_d = sts_i.full ? S_FST : S_OUT;
      S_FST:  state_d = S_DIVF;
      S_DIVF: if (sts_i.div_done) state_d = S_DIVS;
      S_DIVS: if (sts_i.div_done) state_d = S_MUL;
      S_MUL:  state_d = S_CMP;
      S_CMP:  state_d = S_OUT;
      S_OUT:  if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_RDF: cmd_o.rd_fast = 1'b1;
      S_RDS: cmd_o.rd_slow = 1'b1;
      S_UPD: cmd_o.update = 1'b1;
      // sums are updated by now
      S_FST: cmd_o.div_start = 1'b1;
      S_DIVF: begin
        cmd_o.div_start = sts_i.div_done;
        cmd_o.div_sel   = sts_i.div_done;
      end
      S_DIVS: cmd_o.div_sel = 1'b1;
      S_MUL:  cmd_o.mul = 1'b1;
      S_CMP:  cmd_o.compare = 1'b1;
      S_OUT:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/emac_div.sv
// Restoring divider: signed 52-bit dividend by unsigned window, floor quotient and remainder.
module emac_div
  import emac_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [SumW-1:0] num_i,
  input  logic [RegW-1:0]        den_i,
  output logic                   done_o,
  output logic signed [SumW-1:0] quot_o,
  output logic [RegW-1:0]        rem_o
);

  localparam int unsigned CntW = $clog2(SumW + 1);

  logic [SumW-1:0]   mag_q, mag_d;     // shifts out dividend, in quotient
  logic [RegW:0]     part_q, part_d;
  logic [RegW-1:0]   den_q;
  logic              neg_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic [RegW:0]     trial;
  logic [SumW-1:0]   qpos;
  logic [RegW-1:0]   rpos;

  always_comb begin
    trial  = {part_q[RegW-1:0], mag_q[SumW-1]};
    mag_d  = mag_q;
    part_d = part_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        part_d = trial - {1'b0, den_q};
        mag_d  = {mag_q[SumW-2:0], 1'b1};
      end else begin
        part_d = trial;
        mag_d  = {mag_q[SumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  // Truncated magnitude result, then floor correction for negative dividends.
  always_comb begin
    qpos = mag_q;
    rpos = part_q[RegW-1:0];
    if (neg_q && (rpos != '0)) begin
      quot_o = -$signed(qpos + SumW'(1));
      rem_o  = den_q - rpos;
    end else begin
      quot_o = neg_q ? -$signed(qpos) : $signed(qpos);
      rem_o  = rpos;
    end
  end

  assign done_o = !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(SumW);
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q  <= num_i[SumW-1];
      mag_q  <= num_i[SumW-1] ? SumW'(-num_i) : num_i;
      part_q <= '0;
      den_q  <= den_i;
    end else begin
      mag_q  <= mag_d;
      part_q <= part_d;
    end
  end

endmodule

FILE: rtl/emac_dp.sv
// Datapath: price ring, running sums, divider and exact mean comparison.
module emac_dp
  import emac_pkg::*;
#(
  parameter int unsigned MaxWindow = MaxWindowDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  emac_cmd_t                cmd_i,
  output emac_sts_t                sts_o,
  input  logic signed [PriceW-1:0] close_ticks_i,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [RegW-1:0]          cfg_data_i,
  output logic signed [1:0]        direction_o,
  output logic [1:0]               status_o
);

  localparam int unsigned AddrW = $clog2(MaxWindow);
  localparam logic signed [PriceW-1:0] Bound = PriceW'(64'sd1 << 40);

  logic [RegW-1:0] fast_q, slow_q;
  logic [AddrW-1:0] wptr_q;
  logic [RegW-1:0]  fill_q;
  logic signed [SumW-1:0] fsum_q, ssum_q;
  logic signed [PriceW-1:0] price_q, rd_q, old_fast_q;
  logic signed [PriceW-1:0] ring [MaxWindow];
  logic [AddrW-1:0] rd_addr;
  logic [1:0]       status_q;
  logic signed [1:0] dir_q;
  logic signed [SumW-1:0] fq_q, sq_q, dquot;
  logic [RegW-1:0]  fr_q, drem;
  logic [2*RegW-1:0] left_q, right_q;
  logic             div_done;
  logic             win_bad, price_bad, fill_next_full;
  logic [RegW-1:0]  fill_next;

  assign win_bad = (fast_q == '0) || (fast_q >= slow_q) ||
                   ({{(32-RegW){1'b0}}, slow_q} >= 32'(MaxWindow));
  assign price_bad = (close_ticks_i < -Bound) || (close_ticks_i > Bound);

  assign rd_addr = cmd_i.rd_fast ? wptr_q - AddrW'(fast_q) : wptr_q - AddrW'(slow_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_fast || cmd_i.rd_slow) rd_q <= ring[rd_addr];
    if (cmd_i.update) ring[wptr_q] <= price_q;
  end

  assign fill_next      = (fill_q < slow_q) ? fill_q + 1'b1 : fill_q;
  assign fill_next_full = (fill_next >= slow_q);

  assign sts_o.reject   = (status_q == StWindows) || (status_q == StRange);
  assign sts_o.full     = fill_next_full;
  assign sts_o.div_done = div_done;

  emac_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (cmd_i.div_sel ? ssum_q : fsum_q),
    .den_i  (cmd_i.div_sel ? slow_q : fast_q),
    .done_o (div_done),
    .quot_o (dquot),
    .rem_o  (drem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q   <= RegW'(1);
      slow_q   <= RegW'(2);
      wptr_q   <= '0;
      fill_q   <= '0;
      fsum_q   <= '0;
      ssum_q   <= '0;
      status_q <= StValid;
      dir_q    <= DirFlat;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgFast: fast_q <= cfg_data_i;
        CfgSlow: slow_q <= cfg_data_i;
        default: ;
      endcase
      wptr_q <= '0;
      fill_q <= '0;
      fsum_q <= '0;
      ssum_q <= '0;
    end else begin
      if (cmd_i.load) begin
        dir_q <= DirFlat;
        if (win_bad)        status_q <= StWindows;
        else if (price_bad) status_q <= StRange;
        else                status_q <= StWarming;
      end
      if (cmd_i.update) begin
        fsum_q <= fsum_q + SumW'(price_q)
                  - ((fill_q >= fast_q) ? SumW'(old_fast_q) : '0);
        ssum_q <= ssum_q + SumW'(price_q)
                  - ((fill_q >= slow_q) ? SumW'(rd_q) : '0);
        wptr_q <= wptr_q + 1'b1;
        fill_q <= fill_next;
      end
      if (cmd_i.compare) begin
        status_q <= StValid;
        if (fq_q != sq_q)          dir_q <= (fq_q > sq_q) ? DirUp : DirDown;
        else if (left_q > right_q) dir_q <= DirUp;
        else if (left_q < right_q) dir_q <= DirDown;
        else                       dir_q <= DirFlat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) price_q <= close_ticks_i;
    if (cmd_i.rd_slow) old_fast_q <= rd_q;
    if (cmd_i.div_start && cmd_i.div_sel) begin
      fq_q <= dquot;
      fr_q <= drem;
    end
    if (cmd_i.mul) begin
      sq_q    <= dquot;
      left_q  <= fr_q * slow_q;
      right_q <= drem * fast_q;
    end
  end

  assign direction_o = dir_q;
  assign status_o    = status_q;

endmodule

FILE: rtl/exact_moving_average_crossover.sv
// Top level of the exact dual moving average crossover block.
//
//  channel   | dir | handshake        | payload
//  s_axis    | in  | tvalid/tready    | tdata[41:0] close_ticks (signed), 48 bits
//  m_axis    | out | tvalid/tready    | tdata[1:0] direction, [3:2] status, 8 bits
//  cfg       | in  | cfg_we_i         | cfg_idx_i 0 fast_window, 1 slow_window
//
// One word at a time. A rejected word (windows invalid, price out of range) shows its
// result after the fast read state, a warming word after the fast and slow reads and
// the update, a full-window word after those, a start state, two 52-step serial
// divisions run back to back on the one divider, the multiply and the compare.
// Result is held until m_axis_tready and the next word is taken no earlier than the
// cycle after. Reset leaves fast 1, slow 2 and empty history; any config write clears
// the history. Ring entries are read before written, but only written ones are used.
module exact_moving_average_crossover
  import emac_pkg::*;
#(
  parameter int unsigned MaxWindow = MaxWindowDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [47:0]         s_axis_tdata,   // [41:0] close_ticks
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // [1:0] direction, [3:2] status
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [RegW-1:0]     cfg_data_i
);

  emac_cmd_t         cmd;
  emac_sts_t         sts;
  logic signed [1:0] direction;
  logic [1:0]        status;

  emac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  emac_dp #(.MaxWindow(MaxWindow)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .close_ticks_i(s_axis_tdata[PriceW-1:0]),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .direction_o  (direction),
    .status_o     (status)
  );

  assign m_axis_tdata = {4'b0, status, direction};

endmodule

FILE: rtl/emac_checker.sv
// Port-level assertions for the crossover block, bound to the top level.
module emac_checker
  import emac_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // Only one word in flight.
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("in and out both open");

  // Direction is zero whenever a shown result's status is not valid.
  a_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[3:2] != StValid) |-> m_axis_tdata[1:0] == 2'b00)
    else $error("direction set on non-valid status");

  // Direction is never the unused code.
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'b10) else $error("bad direction code");

  // Stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind exact_moving_average_crossover emac_checker u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
